// ----- hw/rtl/bounded_bucket_histogram_macros.svh -----
// Assertion macros for the bounded bucket histogram.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef BOUNDED_BUCKET_HISTOGRAM_MACROS_SVH
`define BOUNDED_BUCKET_HISTOGRAM_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BBH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bbh same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define BBH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bbh next-cycle check failed");

`endif

// ----- hw/rtl/bbh_pkg.sv -----
// Shared types and constants for the bounded bucket histogram.
// No dependencies; used by every module of the block.
package bbh_pkg;

  localparam int unsigned MaxBucketsDef = 7;
  localparam int unsigned NumBoundRegs  = 7;
  localparam int unsigned ValueW        = 32;
  localparam int unsigned IdxW          = 3;
  localparam int unsigned CmdQDepth     = 4;
  localparam int unsigned CmdQPtrW      = $clog2(CmdQDepth);

  // Configuration register indexes
  localparam logic [IdxW-1:0] RegActive = 3'd0;
  localparam logic [IdxW-1:0] RegBound0 = 3'd1;

  typedef enum logic {
    ActRecord = 1'b0,
    ActReport = 1'b1
  } action_e;

  typedef enum logic {
    CmdSample = 1'b0,
    CmdReport = 1'b1
  } cmd_op_e;

  typedef enum logic {
    BkIdle   = 1'b0,
    BkReport = 1'b1
  } back_state_e;

  typedef struct packed {
    logic                     action;
    logic signed [ValueW-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]          bucket_index;
    logic signed [ValueW-1:0] bucket_bound;
    logic [ValueW-1:0]        bucket_total;
    logic                     last_bucket;
  } out_item_t;

  typedef struct packed {
    cmd_op_e         op;
    logic [IdxW-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef logic [NumBoundRegs-1:0][ValueW-1:0] bound_vec_t;

endpackage

// ----- hw/rtl/bbh_front.sv -----
// Front end: takes start beats, classifies samples against the boundaries.
// Depends on bbh_pkg.
module bbh_front #(
  parameter int unsigned MaxBuckets = bbh_pkg::MaxBucketsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  bbh_pkg::in_item_t               item_i,
  input  logic [bbh_pkg::IdxW-1:0]        used_n_i,
  input  bbh_pkg::bound_vec_t             bounds_i,
  input  logic                            q_full_i,
  output logic                            busy_o,
  output logic                            push_o,
  output bbh_pkg::cmd_t                   cmd_o
);
  import bbh_pkg::*;

  logic            valid_q, valid_d;
  cmd_t            cmd_q, cmd_d;
  logic            hit;
  logic [IdxW-1:0] hit_idx;
  logic            accept;

  // parallel compares, lowest index wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = MaxBuckets - 1; i >= 0; i--) begin
      if ((IdxW'(i) < used_n_i) && ($signed(bounds_i[i]) > item_i.sample_value)) begin
        hit     = 1'b1;
        hit_idx = IdxW'(i);
      end
    end
  end

  assign push_o = valid_q && !q_full_i;
  assign busy_o = valid_q && q_full_i;
  assign accept = start_i && !busy_o;
  assign cmd_o  = cmd_q;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (accept) begin
      if (item_i.action == ActReport) begin
        valid_d = 1'b1;
        cmd_d   = '{op: CmdReport, idx: '0};
      end else begin
        // out-of-range samples are dropped here
        valid_d = hit;
        cmd_d   = '{op: CmdSample, idx: hit_idx};
      end
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

// ----- hw/rtl/bbh_cmd_fifo.sv -----
// Small command queue between front and back end.
// Depends on bbh_pkg.
module bbh_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bbh_pkg::cmd_t     cmd_i,
  input  logic              pop_i,
  output bbh_pkg::cmd_t     cmd_o,
  output bbh_pkg::q_stat_t  stat_o
);
  import bbh_pkg::*;

  cmd_t                mem_q [CmdQDepth];
  logic [CmdQPtrW-1:0] wr_q, rd_q;
  logic [CmdQPtrW:0]   cnt_q;
  logic                do_push, do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == (CmdQPtrW + 1)'(CmdQDepth));
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cmd_o        = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ----- hw/rtl/bbh_back.sv -----
// Back end: bucket counters, saturating increments and the report sequencer.
// Depends on bbh_pkg.
module bbh_back #(
  parameter int unsigned MaxBuckets = bbh_pkg::MaxBucketsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  input  bbh_pkg::cmd_t            q_cmd_i,
  output logic                     q_pop_o,
  input  logic [bbh_pkg::IdxW-1:0] used_n_i,
  input  bbh_pkg::bound_vec_t      bounds_i,
  output logic                     result_valid_o,
  output bbh_pkg::out_item_t       result_o
);
  import bbh_pkg::*;

  localparam int unsigned CntIdxW = (MaxBuckets > 1) ? $clog2(MaxBuckets) : 1;

  back_state_e       state_q, state_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   last_q, last_d;
  logic [ValueW-1:0] cnt_q [MaxBuckets];
  logic [ValueW-1:0] cnt_d [MaxBuckets];
  out_item_t         res_q, res_d;
  logic              rvalid_q, rvalid_d;
  logic              inc, clr_all, emit, at_last;

  assign at_last = (idx_q == last_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle: begin
        if (q_valid_i && q_cmd_i.op == CmdReport && used_n_i != '0) begin
          state_d = BkReport;
        end
      end
      BkReport: begin
        if (at_last) begin
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop_o = 1'b0;
    inc     = 1'b0;
    clr_all = 1'b0;
    emit    = 1'b0;
    idx_d   = idx_q;
    last_d  = last_q;
    unique case (state_q)
      BkIdle: begin
        q_pop_o = q_valid_i;
        if (q_valid_i) begin
          if (q_cmd_i.op == CmdSample) begin
            inc = 1'b1;
          end else begin
            clr_all = (used_n_i == '0);
            idx_d   = '0;
            last_d  = used_n_i - 1'b1;
          end
        end
      end
      BkReport: begin
        emit    = 1'b1;
        clr_all = at_last;
        idx_d   = idx_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < MaxBuckets; i++) begin
      cnt_d[i] = cnt_q[i];
      if (clr_all) begin
        cnt_d[i] = '0;
      end else if (inc && q_cmd_i.idx == IdxW'(i) && cnt_q[i] != '1) begin
        cnt_d[i] = cnt_q[i] + 1'b1;
      end
    end
  end

  always_comb begin
    rvalid_d           = emit;
    res_d              = res_q;
    if (emit) begin
      res_d.bucket_index = idx_q;
      res_d.bucket_bound = bounds_i[idx_q];
      res_d.bucket_total = cnt_q[idx_q[CntIdxW-1:0]];
      res_d.last_bucket  = at_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BkIdle;
      idx_q    <= '0;
      last_q   <= '0;
      rvalid_q <= 1'b0;
      for (int i = 0; i < MaxBuckets; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      last_q   <= last_d;
      rvalid_q <= rvalid_d;
      for (int i = 0; i < MaxBuckets; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = rvalid_q;
  assign result_o       = res_q;

endmodule

// ----- hw/rtl/bounded_bucket_histogram.sv -----
// Top level of the bounded bucket histogram: config registers, front end,
// command queue and back end. Depends on bbh_pkg, bbh_front, bbh_cmd_fifo,
// bbh_back and bounded_bucket_histogram_macros.svh.
//
// Usage
//   Input beat: start_i high while busy_o is low. item_i.action selects
//   record (sample_value is binned) or report (dump and clear counters).
//   Config: cfg_we_i writes register cfg_idx_i (0 = active bucket count,
//   1..7 = boundaries 0..6) with cfg_wdata_i at the clock edge; the user
//   must write only while the block is idle, which the block does not enforce.
//   Results: result_valid_o strobes for one cycle per beat; no back-pressure.
//   A report gives one beat per active bucket in index order, the final one
//   flagged by last_bucket, then all counters read zero.
// Timing
//   Samples sustain one beat per cycle while busy_o is low; the back end
//   takes one command per cycle while idle. A report holds the back end:
//   it takes the command, then gives one beat per cycle. A four-entry
//   command queue absorbs beats meanwhile; busy_o rises only when it is
//   full and the front stage holds a command.
// Reset
//   Asynchronous, active low: counters, active count and boundaries go to
//   zero, queue empties, no result beat is pending.
module bounded_bucket_histogram #(
  parameter int unsigned MAX_BUCKETS = bbh_pkg::MaxBucketsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  bbh_pkg::in_item_t          item_i,
  output logic                       busy_o,
  input  logic                       cfg_we_i,
  input  logic [bbh_pkg::IdxW-1:0]   cfg_idx_i,
  input  logic [bbh_pkg::ValueW-1:0] cfg_wdata_i,
  output logic                       result_valid_o,
  output bbh_pkg::out_item_t         result_o
);
  import bbh_pkg::*;

`include "bounded_bucket_histogram_macros.svh"

  logic [IdxW-1:0] active_q;
  bound_vec_t      bounds_q;
  logic [IdxW-1:0] used_n;

  logic            push;
  cmd_t            front_cmd, q_cmd;
  q_stat_t         q_stat;
  logic            pop;

  // Config registers; an active count above the build limit is clamped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      bounds_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegActive) begin
        active_q <= cfg_wdata_i[IdxW-1:0];
      end else begin
        bounds_q[cfg_idx_i - RegBound0] <= cfg_wdata_i;
      end
    end
  end

  assign used_n = (active_q > IdxW'(MAX_BUCKETS)) ? IdxW'(MAX_BUCKETS) : active_q;

  bbh_front #(
    .MaxBuckets(MAX_BUCKETS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .item_i   (item_i),
    .used_n_i (used_n),
    .bounds_i (bounds_q),
    .q_full_i (q_stat.full),
    .busy_o   (busy_o),
    .push_o   (push),
    .cmd_o    (front_cmd)
  );

  bbh_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .pop_i  (pop),
    .cmd_o  (q_cmd),
    .stat_o (q_stat)
  );

  bbh_back #(
    .MaxBuckets(MAX_BUCKETS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (!q_stat.empty),
    .q_cmd_i        (q_cmd),
    .q_pop_o        (pop),
    .used_n_i       (used_n),
    .bounds_i       (bounds_q),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // a report streams without gaps until its last beat
  `BBH_ASSERT_NEXT(a_report_gapless, result_valid_o && !result_o.last_bucket, result_valid_o)
  // reported index stays within the built counters
  `BBH_ASSERT_NOW(a_index_range, result_valid_o, result_o.bucket_index < IdxW'(MAX_BUCKETS))
  // indexes within a report climb by one
  `BBH_ASSERT_NOW(a_index_step, result_valid_o && result_o.bucket_index != '0, $past(result_valid_o) && ($past(result_o.bucket_index) + 1'b1 == result_o.bucket_index))

endmodule

// ----- sim/tb_bounded_bucket_histogram.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for bounded_bucket_histogram: directed table, then random phases.
// Depends on bbh_pkg and the block's RTL only; results are checked against an in-bench model.
module tb_bounded_bucket_histogram;
  import bbh_pkg::*;

  // Cycles let pass after the last due beat before touching config or ending:
  // samples make no beat, so up to a full command queue may still be in flight.
  localparam int unsigned SettleCycles = 20;
  // Cycles with neither an input beat nor a result beat before giving up.
  localparam int unsigned StallLimit   = 1000;

  localparam logic [ValueW-1:0] ValMin = 32'h8000_0000;
  localparam logic [ValueW-1:0] ValMax = 32'h7FFF_FFFF;

  // Report beats that can be read straight off the table (single top bucket).
  localparam out_item_t TopTwo  = '{bucket_index: 3'd0, bucket_bound: ValMax,
                                    bucket_total: 32'd2, last_bucket: 1'b1};
  localparam out_item_t TopNone = '{bucket_index: 3'd0, bucket_bound: ValMax,
                                    bucket_total: 32'd0, last_bucket: 1'b1};
  localparam out_item_t NoBeat  = '0;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start_i     = 1'b0;
  in_item_t             item_i      = '0;
  logic                 busy_o;
  logic                 cfg_we_i    = 1'b0;
  logic [IdxW-1:0]      cfg_idx_i   = '0;
  logic [ValueW-1:0]    cfg_wdata_i = '0;
  logic                 result_valid_o;
  out_item_t            result_o;

  bounded_bucket_histogram u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .item_i         (item_i),
    .busy_o         (busy_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Histogram model: own copy of registers and counters, updated as beats are
  // accepted; report beats it predicts queue up in due_beats.
  // ---------------------------------------------------------------------------
  logic [IdxW-1:0]   active_m          = '0;
  logic [ValueW-1:0] bound_m  [NumBoundRegs] = '{default: '0};
  logic [ValueW-1:0] count_m  [MaxBucketsDef] = '{default: '0};
  out_item_t         due_beats [$];
  int unsigned       n_bad = 0;

  function automatic void bin_or_dump(input in_item_t it, output out_item_t beats[$]);
    int used;
    bit hit;
    used  = (active_m > MaxBucketsDef) ? MaxBucketsDef : active_m;
    beats = {};
    hit   = 1'b0;
    if (it.action == ActRecord) begin
      // priority over parallel compares: lowest index whose bound exceeds the sample
      for (int i = 0; i < used; i++) begin
        if (!hit && $signed(bound_m[i]) > it.sample_value) begin
          hit = 1'b1;
          if (count_m[i] != '1) count_m[i]++;   // saturate, never wrap
        end
      end
    end else begin
      for (int i = 0; i < used; i++)
        beats.push_back('{bucket_index: IdxW'(i), bucket_bound: bound_m[i],
                          bucket_total: count_m[i], last_bucket: (i == used - 1)});
      // report clears every counter, inactive ones too
      foreach (count_m[i]) count_m[i] = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Everything is driven by NBA just after a rising edge; a beat is
  // taken at the edge where start_i is high and busy_o low.
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [IdxW-1:0] idx, logic [ValueW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == RegActive) active_m = val[IdxW-1:0];
    else                  bound_m[idx - RegBound0] = val;
  endtask

  // Count register gets random junk above its three bits, which must be dropped.
  task automatic load_cfg(logic [IdxW-1:0] act, logic [ValueW-1:0] bnd [NumBoundRegs]);
    logic [ValueW-1:0] w;
    w         = $urandom();
    w[IdxW-1:0] = act;
    write_reg(RegActive, w);
    for (int i = 0; i < NumBoundRegs; i++) write_reg(IdxW'(RegBound0 + i), bnd[i]);
    cfg_we_i <= 1'b0;
  endtask

  // typed: the row carries its own expectation (one beat if 'one', else none)
  task automatic put_beat(action_e act, logic [ValueW-1:0] val, bit typed, bit one,
                          out_item_t want);
    in_item_t  it;
    out_item_t beats [$];
    it.action       = act;
    it.sample_value = val;
    start_i <= 1'b1;
    item_i  <= it;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    bin_or_dump(it, beats);
    if (typed) begin
      if (one) due_beats.push_back(want);
    end else begin
      foreach (beats[k]) due_beats.push_back(beats[k]);
    end
  endtask

  // ~20 % of input cycles idle: a one-cycle gap after about a quarter of the beats.
  task automatic maybe_idle(bit steady);
    if (!steady && $urandom_range(0, 99) < 25) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Block is idle once nothing is due and the queue has had time to empty.
  task automatic settle();
    start_i <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobed beat against the oldest due one.
  // ---------------------------------------------------------------------------
  out_item_t head_beat;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (due_beats.size() == 0) begin
        $error("unexpected result beat: bucket_index %0d", result_o.bucket_index);
        n_bad++;
      end else begin
        head_beat = due_beats.pop_front();
        if (result_o.bucket_index !== head_beat.bucket_index) begin
          $error("bucket_index: expected %0d, got %0d",
                 head_beat.bucket_index, result_o.bucket_index);
          n_bad++;
        end
        if (result_o.bucket_bound !== head_beat.bucket_bound) begin
          $error("bucket_bound: expected %0d, got %0d",
                 head_beat.bucket_bound, result_o.bucket_bound);
          n_bad++;
        end
        if (result_o.bucket_total !== head_beat.bucket_total) begin
          $error("bucket_total: expected %0d, got %0d",
                 head_beat.bucket_total, result_o.bucket_total);
          n_bad++;
        end
        if (result_o.last_bucket !== head_beat.last_bucket) begin
          $error("last_bucket: expected %0b, got %0b",
                 head_beat.last_bucket, result_o.last_bucket);
          n_bad++;
        end
      end
    end
  end

  // Watchdog: restarts on any beat in either direction.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || result_valid_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == StallLimit) begin
        $display("** bounded_bucket_histogram: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table. Phase 0 runs on reset values; each later phase loads the
  // matching config set first. Typed rows carry their expectation inline.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [IdxW-1:0]   act;
    logic [ValueW-1:0] bnd [NumBoundRegs];
  } cfg_set_t;

  typedef struct {
    int unsigned       phase;
    action_e           act;
    logic [ValueW-1:0] val;
    bit                typed;
    bit                one;
    out_item_t         want;
  } dir_row_t;

  localparam logic [ValueW-1:0] Spread [NumBoundRegs] =
    '{32'h8000_0001, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd100, 32'h7FFF_FFFE, ValMax};

  cfg_set_t dir_cfg [8] = '{
    '{3'd0, '{default: '0}},                                      // reset values
    '{3'd1, '{ValMax, 0, 0, 0, 0, 0, 0}},                         // single top bucket
    '{3'd7, Spread},                                              // all seven, extremes
    '{3'd3, '{32'd10, 32'hFFFF_FFFB, 32'd20, 0, 0, 0, 0}},        // out of order
    '{3'd7, Spread},
    '{3'd3, Spread},                                              // fewer than counted
    '{3'd0, Spread},                                              // none active
    '{3'd7, Spread}
  };

  dir_row_t dir_rows [25] = '{
    // after reset: nothing active, report gives nothing
    '{0, ActReport, 32'd0,         1, 0, NoBeat},
    '{0, ActRecord, 32'd5,         1, 0, NoBeat},
    '{0, ActReport, 32'd0,         1, 0, NoBeat},
    // one bucket bounded at max: max itself is dropped
    '{1, ActRecord, ValMin,        1, 0, NoBeat},
    '{1, ActRecord, ValMax,        1, 0, NoBeat},
    '{1, ActRecord, 32'd0,         1, 0, NoBeat},
    '{1, ActReport, 32'd0,         1, 1, TopTwo},
    '{1, ActReport, 32'd0,         1, 1, TopNone},
    // seven buckets, samples on and around the boundaries
    '{2, ActRecord, ValMin,        0, 0, NoBeat},
    '{2, ActRecord, 32'hFFFF_FFFF, 0, 0, NoBeat},
    '{2, ActRecord, 32'd0,         0, 0, NoBeat},
    '{2, ActRecord, 32'h7FFF_FFFE, 0, 0, NoBeat},
    '{2, ActRecord, ValMax,        0, 0, NoBeat},
    '{2, ActRecord, 32'd100,       0, 0, NoBeat},
    '{2, ActReport, ValMax,        0, 0, NoBeat},   // sample field ignored
    // unsorted bounds: lowest index wins
    '{3, ActRecord, 32'd0,         0, 0, NoBeat},
    '{3, ActRecord, 32'd15,        0, 0, NoBeat},
    '{3, ActRecord, 32'hFFFF_FFF6, 0, 0, NoBeat},
    '{3, ActRecord, 32'd20,        0, 0, NoBeat},
    '{3, ActReport, ValMin,        0, 0, NoBeat},
    // fill top and bottom, report with three active, then none, then all seven
    '{4, ActRecord, 32'h7FFF_FFFE, 0, 0, NoBeat},
    '{4, ActRecord, ValMin,        0, 0, NoBeat},
    '{5, ActReport, 32'd0,         0, 0, NoBeat},
    '{6, ActReport, 32'd0,         1, 0, NoBeat},
    '{7, ActReport, 32'd0,         0, 0, NoBeat}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned       cur;
    logic [IdxW-1:0]   act;
    logic [ValueW-1:0] bnd [NumBoundRegs];
    logic [ValueW-1:0] val;
    int                pool [$];
    action_e           op;
    int unsigned       pick;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    cur = 0;
    foreach (dir_rows[r]) begin
      if (dir_rows[r].phase != cur) begin
        cur = dir_rows[r].phase;
        settle();
        load_cfg(dir_cfg[cur].act, dir_cfg[cur].bnd);
      end
      put_beat(dir_rows[r].act, dir_rows[r].val, dir_rows[r].typed, dir_rows[r].one,
               dir_rows[r].want);
      maybe_idle(1'b0);
    end

    // Random phases: fresh config each, ~30 beats apiece. Phase 4 runs with no
    // input gaps at all; phase 5 loads bounds unsorted.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1:       act = 3'd0;
        2:       act = 3'd1;
        6:       act = 3'd3;
        3, 5:    act = IdxW'($urandom_range(1, 7));
        default: act = 3'd7;
      endcase
      pool = {};
      for (int i = 0; i < NumBoundRegs; i++)
        pool.push_back((ph % 2 == 0) ? int'($urandom_range(0, 400)) - 200 : int'($urandom()));
      if (ph != 5) pool.sort();
      foreach (bnd[i]) bnd[i] = pool[i];

      settle();
      load_cfg(act, bnd);

      repeat (30) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          case ($urandom_range(0, 3))
            0:       val = ValMin;
            1:       val = ValMax;
            2:       val = '0;
            default: val = '1;
          endcase
        end else if (pick < 5) begin
          // just below, on, or just above a boundary
          val = bound_m[$urandom_range(0, NumBoundRegs - 1)] + $urandom_range(0, 2) - 1;
        end else begin
          val = $urandom();
        end
        op = ($urandom_range(0, 7) == 0) ? ActReport : ActRecord;
        put_beat(op, val, 1'b0, 1'b0, NoBeat);
        maybe_idle(ph == 4);
      end
    end

    settle();
    if (n_bad == 0) begin
      $display("** bounded_bucket_histogram: PASSED **");
    end else begin
      $display("** bounded_bucket_histogram: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/bbh_pkg.sv
hw/rtl/bbh_front.sv
hw/rtl/bbh_cmd_fifo.sv
hw/rtl/bbh_back.sv
hw/rtl/bounded_bucket_histogram.sv
sim/tb_bounded_bucket_histogram.sv
